FILE: hdl/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, constants and the attenuation table for the three-tone,
// one-noise sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

    // number of square-tone channels, 1 to 3
    localparam int TONE_CHANNELS = 3;
    // bits of a tone channel index
    localparam int CH_W    = (TONE_CHANNELS > 1) ? $clog2(TONE_CHANNELS) : 1;
    // tone channel whose period the noise may follow
    localparam int LINK_CH = (TONE_CHANNELS > 2) ? 2 : 0;

    // widths
    localparam int PER_W  = 10;
    localparam int CNT_W  = 16;
    localparam int ATT_W  = 4;
    localparam int TICK_W = 10;
    localparam int LVL_W  = 16;
    localparam int ALU_W  = 19;
    localparam int OUT_W  = 17;

    // register numbers with a meaning of their own
    localparam logic [2:0] REG_NOISE_MODE = 3'd6;
    localparam logic [2:0] REG_NOISE_ATT  = 3'd7;

    // noise period select codes (mode bits 1..0)
    localparam logic [1:0] NSEL_16   = 2'd0;
    localparam logic [1:0] NSEL_32   = 2'd1;
    localparam logic [1:0] NSEL_64   = 2'd2;
    localparam logic [1:0] NSEL_LINK = 2'd3;

    // fixed noise periods and reset values
    localparam logic [PER_W-1:0] NPER_16    = 10'h010;
    localparam logic [PER_W-1:0] NPER_32    = 10'h020;
    localparam logic [PER_W-1:0] NPER_64    = 10'h040;
    localparam logic [CNT_W-1:0] LFSR_SEED  = 16'h8000;
    localparam logic [ATT_W-1:0] ATT_SILENT = 4'd15;
    localparam logic [TICK_W-1:0] TICKS_RST = 10'd4;

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // register file contents seen by the engine
    typedef struct packed {
        logic [TICK_W-1:0]                    ticks;
        logic [TONE_CHANNELS-1:0][PER_W-1:0]  periods;
        logic [3:0][ATT_W-1:0]                atten;
        logic [2:0]                           noise_mode;
        logic [PER_W-1:0]                     nz_period;
        logic                                 reseed;
    } t_regs;

    // request to the shared adder/subtractor
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    // attenuation level, 1.0 = 32768
    function automatic logic [LVL_W-1:0] att_level(input logic [ATT_W-1:0] att);
        logic [LVL_W-1:0] lvl;
        case (att)
            4'd0:    lvl = 16'd32768;
            4'd1:    lvl = 16'd26028;
            4'd2:    lvl = 16'd20677;
            4'd3:    lvl = 16'd16423;
            4'd4:    lvl = 16'd13045;
            4'd5:    lvl = 16'd10361;
            4'd6:    lvl = 16'd8231;
            4'd7:    lvl = 16'd6537;
            4'd8:    lvl = 16'd5194;
            4'd9:    lvl = 16'd4125;
            4'd10:   lvl = 16'd3277;
            4'd11:   lvl = 16'd2602;
            4'd12:   lvl = 16'd2068;
            4'd13:   lvl = 16'd1642;
            4'd14:   lvl = 16'd1304;
            default: lvl = 16'd0;
        endcase
        return lvl;
    endfunction

    // zero period counts as one
    function automatic logic [PER_W-1:0] eff_period(input logic [PER_W-1:0] p);
        return (p == '0) ? PER_W'(1) : p;
    endfunction

endpackage

FILE: hdl/psg_alu.sv
// ----------------------------------------------------------------------------
// psg_alu
// Shared adder/subtractor used for counter advance, division steps, noise
// period subtraction, mixing and rounding.
// ----------------------------------------------------------------------------
module psg_alu (
    input  psg_pkg::t_alu_req          i_req,
    output logic [psg_pkg::ALU_W-1:0]  o_res
);
    import psg_pkg::*;

    // add or subtract, two's complement
    assign o_res = i_req.sub ? (i_req.a - i_req.b) : (i_req.a + i_req.b);

endmodule

FILE: hdl/psg_regfile.sv
// ----------------------------------------------------------------------------
// psg_regfile
// Register byte decoder: latch/data and continuation bytes, periods,
// attenuations, noise mode and the tick configuration register.
// ----------------------------------------------------------------------------
module psg_regfile (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  logic [7:0]                  i_byte,
    input  logic                        i_cfg_we,
    input  logic [psg_pkg::TICK_W-1:0]  i_cfg_wdata,
    output psg_pkg::t_regs              o_regs
);
    import psg_pkg::*;

    logic [TICK_W-1:0]                   r_ticks, n_ticks;
    logic [2:0]                          r_latch, n_latch;
    logic [TONE_CHANNELS-1:0][PER_W-1:0] r_per, n_per;
    logic [3:0][ATT_W-1:0]               r_att, n_att;
    logic [2:0]                          r_mode, n_mode;
    logic [PER_W-1:0]                    r_nper, n_nper;
    logic [1:0]                          ch;
    logic                                ch_ok;
    logic [PER_W-1:0]                    link_per;
    logic                                reseed;

    // decode of one register byte
    always_comb begin
        n_ticks  = i_cfg_we ? i_cfg_wdata : r_ticks;
        n_latch  = r_latch;
        n_per    = r_per;
        n_att    = r_att;
        n_mode   = r_mode;
        n_nper   = r_nper;
        reseed   = 1'b0;
        ch       = i_byte[7] ? i_byte[6:5] : r_latch[2:1];
        ch_ok    = ({1'b0, ch} < 3'(TONE_CHANNELS));
        link_per = PER_W'(1);
        if (i_wr) begin
            if (i_byte[7]) begin
                n_latch = i_byte[6:4];
                case (i_byte[6:4])
                    REG_NOISE_MODE: begin
                        n_mode = i_byte[2:0];
                        reseed = 1'b1;
                    end
                    REG_NOISE_ATT: n_att[3] = i_byte[3:0];
                    default: begin
                        if (i_byte[4])
                            n_att[ch] = i_byte[3:0];
                        else if (ch_ok)
                            n_per[ch[CH_W-1:0]][3:0] = i_byte[3:0];
                    end
                endcase
            end else if (!r_latch[0] && r_latch < REG_NOISE_MODE && ch_ok) begin
                n_per[ch[CH_W-1:0]][PER_W-1:4] = i_byte[5:0];
            end
        end
        // noise period: fixed by the mode, or following the linked tone
        if (TONE_CHANNELS > 2)
            link_per = eff_period(n_per[LINK_CH]);
        if (reseed) begin
            case (n_mode[1:0])
                NSEL_16: n_nper = NPER_16;
                NSEL_32: n_nper = NPER_32;
                NSEL_64: n_nper = NPER_64;
                default: n_nper = link_per;
            endcase
        end else if (i_wr && !i_byte[7] && !r_latch[0] && r_latch < REG_NOISE_MODE
                     && ch_ok && ch == 2'(LINK_CH) && TONE_CHANNELS > 2
                     && r_mode[1:0] == NSEL_LINK) begin
            n_nper = link_per;
        end
    end

    // register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= TICKS_RST;
            r_latch <= '0;
            r_per   <= '0;
            r_att   <= {4{ATT_SILENT}};
            r_mode  <= '0;
            r_nper  <= NPER_16;
        end else begin
            r_ticks <= n_ticks;
            r_latch <= n_latch;
            r_per   <= n_per;
            r_att   <= n_att;
            r_mode  <= n_mode;
            r_nper  <= n_nper;
        end
    end

    assign o_regs.ticks        = r_ticks;
    assign o_regs.periods      = r_per;
    assign o_regs.atten        = r_att;
    assign o_regs.noise_mode   = r_mode;
    assign o_regs.nz_period    = r_nper;
    assign o_regs.reseed       = reseed;

endmodule

FILE: hdl/psg_engine.sv
// ----------------------------------------------------------------------------
// psg_engine
// Sample sequencer: advances the tone and noise counters, finds whole
// periods passed with restoring division steps, steps the noise shift
// register, mixes the channels and holds the result for transfer.
// ----------------------------------------------------------------------------
module psg_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  psg_pkg::t_regs              i_regs,
    output psg_pkg::t_alu_req           o_alu_req,
    input  logic [psg_pkg::ALU_W-1:0]   i_alu_res,
    output logic                        o_busy,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [psg_pkg::OUT_W-1:0]   o_sample
);
    import psg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_DIV, S_NADD, S_NSUB, S_MIX, S_MIXN, S_ROUND
    } t_state;

    t_state                              r_state;
    logic [CH_W-1:0]                     r_ch;
    logic [3:0]                          r_bit;
    logic [CNT_W-1:0]                    r_work;
    logic [PER_W-1:0]                    r_rem;
    logic [TONE_CHANNELS-1:0][CNT_W-1:0] r_tcnt;
    logic [TONE_CHANNELS-1:0]            r_tneg;
    logic [CNT_W-1:0]                    r_ncnt;
    logic [CNT_W-1:0]                    r_lfsr;
    logic                                r_nneg;
    logic [ALU_W-1:0]                    r_sum;
    logic                                r_out_valid;
    logic [OUT_W-1:0]                    r_out;

    logic [PER_W:0]     trial;
    logic [PER_W-1:0]   p_eff;
    logic [PER_W-1:0]   np_eff;
    logic               fits;
    logic [PER_W-1:0]   n_rem;
    logic               fb;
    logic [LVL_W-1:0]   lvl;
    logic               last_ch;
    logic               out_free;

    // operands for the shared unit
    always_comb begin
        p_eff   = eff_period(i_regs.periods[r_ch]);
        np_eff  = eff_period(i_regs.nz_period);
        trial   = {r_rem, r_work[r_bit]};
        fits    = !i_alu_res[ALU_W-1];
        n_rem   = fits ? i_alu_res[PER_W-1:0] : trial[PER_W-1:0];
        fb      = i_regs.noise_mode[2] ? (r_lfsr[0] ^ r_lfsr[1]) : r_lfsr[0];
        lvl     = (r_state == S_MIXN) ? att_level(i_regs.atten[3])
                                      : att_level(i_regs.atten[2'(r_ch)]);
        last_ch = (r_ch == CH_W'(TONE_CHANNELS - 1));
        out_free = !r_out_valid || !i_out_stall;
        o_alu_req = '0;
        case (r_state)
            S_ADD: begin
                o_alu_req.a = ALU_W'(r_tcnt[r_ch]);
                o_alu_req.b = ALU_W'(i_regs.ticks);
            end
            S_DIV: begin
                o_alu_req.a   = ALU_W'(trial);
                o_alu_req.b   = ALU_W'(p_eff);
                o_alu_req.sub = 1'b1;
            end
            S_NADD: begin
                o_alu_req.a = ALU_W'(r_ncnt);
                o_alu_req.b = ALU_W'(i_regs.ticks);
            end
            S_NSUB: begin
                o_alu_req.a   = ALU_W'(r_ncnt);
                o_alu_req.b   = ALU_W'(np_eff);
                o_alu_req.sub = 1'b1;
            end
            S_MIX: begin
                o_alu_req.a   = r_sum;
                o_alu_req.b   = ALU_W'(lvl);
                o_alu_req.sub = r_tneg[r_ch];
            end
            S_MIXN: begin
                o_alu_req.a   = r_sum;
                o_alu_req.b   = ALU_W'(lvl);
                o_alu_req.sub = r_nneg;
            end
            S_ROUND: begin
                // bias negative sums so the shift truncates toward zero
                o_alu_req.a = r_sum;
                o_alu_req.b = r_sum[ALU_W-1] ? ALU_W'(3) : '0;
            end
            default: o_alu_req = '0;
        endcase
    end

    // sequencer, channel state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_bit       <= '0;
            r_tcnt      <= '0;
            r_tneg      <= '0;
            r_ncnt      <= '0;
            r_lfsr      <= LFSR_SEED;
            r_nneg      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // result register: load on the rounding step, clear on transfer
            if (r_state == S_ROUND && out_free)
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_regs.reseed)
                        r_lfsr <= LFSR_SEED;
                    if (i_start) begin
                        r_ch    <= '0;
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_work  <= i_alu_res[CNT_W-1:0];
                    r_rem   <= '0;
                    r_bit   <= 4'd15;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_bit <= r_bit - 4'd1;
                    if (r_bit == '0) begin
                        // remainder is the new count, quotient parity flips the level
                        r_tcnt[r_ch] <= CNT_W'(n_rem);
                        r_tneg[r_ch] <= r_tneg[r_ch] ^ fits;
                        if (last_ch) begin
                            r_state <= S_NADD;
                        end else begin
                            r_ch    <= r_ch + CH_W'(1);
                            r_state <= S_ADD;
                        end
                    end
                end
                S_NADD: begin
                    r_ncnt  <= i_alu_res[CNT_W-1:0];
                    r_state <= S_NSUB;
                end
                S_NSUB: begin
                    if (fits) begin
                        r_ncnt <= i_alu_res[CNT_W-1:0];
                        r_nneg <= !r_lfsr[0];
                        r_lfsr <= {1'b0, r_lfsr[15] | fb, r_lfsr[14:1]};
                    end else begin
                        r_ch    <= '0;
                        r_sum   <= '0;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_sum <= i_alu_res;
                    if (last_ch)
                        r_state <= S_MIXN;
                    else
                        r_ch <= r_ch + CH_W'(1);
                end
                S_MIXN: begin
                    r_sum   <= i_alu_res;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (out_free) begin
                        r_out       <= i_alu_res[ALU_W-1:2];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out;

endmodule

FILE: hdl/psg_three_tone_one_noise.sv
// ----------------------------------------------------------------------------
// psg_three_tone_one_noise
// Programmable sound generator, three square tones and one noise channel.
// ----------------------------------------------------------------------------
// A register write transfer (command 0) is taken without a stall and the
// input stays ready. A sample transfer (command 1) runs on one shared
// adder/subtractor: per tone channel one counter add and sixteen restoring
// division steps, then one noise counter add and one noise subtract per
// noise shift step plus one, a mixing step per tone and one for the noise,
// and one rounding step. The noise shift register steps once per noise
// period passed in the sample (about ticks_per_sample / noise period). The
// input stalls meanwhile; the result sits in an output register, so a
// finished sample never blocks register writes, and a following sample
// waits only at its rounding step.
// ----------------------------------------------------------------------------
module psg_three_tone_one_noise (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [7:0]                  i_data_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [16:0]          o_sample_value,
    input  logic                        i_cfg_we,
    input  logic [9:0]                  i_cfg_wdata
);
    import psg_pkg::*;

    t_regs              regs;
    t_alu_req           alu_req;
    logic [ALU_W-1:0]   alu_res;
    logic               in_xfer;
    logic               busy;
    logic [OUT_W-1:0]   sample;

    // input transfer
    assign in_xfer    = i_in_valid && !busy;
    assign o_in_stall = busy;

    psg_regfile u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (in_xfer && i_command == CMD_WRITE),
        .i_byte      (i_data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_regs      (regs)
    );

    psg_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    psg_engine u_eng (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_xfer && i_command == CMD_SAMPLE),
        .i_regs      (regs),
        .o_alu_req   (alu_req),
        .i_alu_res   (alu_res),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (sample)
    );

    assign o_sample_value = $signed(sample);

endmodule

FILE: hdl/psg_checker.sv
// ----------------------------------------------------------------------------
// psg_checker
// Port-level checks on the sound generator, bound to the top level.
// ----------------------------------------------------------------------------
module psg_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  logic                i_command,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic signed [16:0]  o_sample_value
);
    import psg_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_value))
        else $error("stalled result changed");

    // result stays within full scale
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_sample_value) <= 17'sd32768)
                     && ($signed(o_sample_value) >= -17'sd32768))
        else $error("sample outside full scale");

    // a register write transfer leaves the input ready
    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_command == CMD_WRITE |=> !o_in_stall)
        else $error("register write held the input");

    // a sample transfer starts work
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_command == CMD_SAMPLE |=> o_in_stall)
        else $error("sample transfer did not start work");

    // reset leaves the block idle and empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("block not idle after reset");

endmodule

bind psg_three_tone_one_noise psg_checker u_psg_checker (.*);
